// File: rtl/erel_pkg.sv
package erel_pkg;

  // Input modes.
  localparam logic [1:0] MODE_ERROR     = 2'd0;
  localparam logic [1:0] MODE_REC_DONE  = 2'd1;
  localparam logic [1:0] MODE_RESTART   = 2'd2;

  // Result actions.
  localparam logic [2:0] ACT_LOG_ONLY     = 3'd0;
  localparam logic [2:0] ACT_IGN_RESET    = 3'd1;
  localparam logic [2:0] ACT_IGN_BUSY     = 3'd2;
  localparam logic [2:0] ACT_NOTIFY       = 3'd3;
  localparam logic [2:0] ACT_FULL_RESET   = 3'd4;
  localparam logic [2:0] ACT_SVC_RECOVERY = 3'd5;
  localparam logic [2:0] ACT_HOUSEKEEP    = 3'd6;

  // Reset causes.
  localparam logic [1:0] CAUSE_NONE      = 2'd0;
  localparam logic [1:0] CAUSE_LEVEL     = 2'd1;
  localparam logic [1:0] CAUSE_TOO_SOON  = 2'd2;
  localparam logic [1:0] CAUSE_TOO_MANY  = 2'd3;

  // Levels that matter to the decision.
  localparam logic [2:0] LEVEL_LOG_ONLY  = 3'd1;
  localparam logic [2:0] LEVEL_RECOVER   = 3'd5;
  localparam logic [2:0] LEVEL_FULL      = 3'd7;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_PERIOD = 1'd1;

  localparam logic [31:0] MIN_INTERVAL_RESET   = 32'd300000;
  localparam logic [31:0] MONITOR_PERIOD_RESET = 32'd3600000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic latch;
    logic decide;
    logic scan;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } dp_status_t;

endpackage

// File: rtl/error_reset_escalation_limiter_core.sv
// Error reset escalation limiter.
// Input channel: in_valid_i / in_stall_o with mode, subsystem, levels, tick
// time stamp and error-safe flag. Output channel: out_valid_o / out_stall_i
// with the action and the reset cause. Configuration: cfg_valid_i /
// cfg_ready_o with a register index and 32-bit data; write only while idle.
// One item is worked on at a time. An accepted item goes through the decide
// and finish states to the output register when no history check is needed;
// when the history ring is walked, a scan state between them checks one entry
// per cycle against the monitor period through a single window comparator.
// The next item is accepted in the cycle after the result is loaded.
// When the receiver stalls, the result holds in the output register while
// the block finishes the next item; that item then waits until the output
// register is taken.
// Reset clears the configuration to its defaults, empties the history ring,
// and clears the last recovery time and the busy flag.
module error_reset_escalation_limiter_core #(
  parameter int unsigned HISTORY_DEPTH = 4,
  parameter int unsigned TIME_WIDTH    = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       mode_i,
  input  logic [3:0]                       subsys_i,
  input  logic [2:0]                       raw_level_i,
  input  logic [2:0]                       escalated_level_i,
  input  logic [31:0]                      now_ticks_i,
  input  logic                             error_safe_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       action_o,
  output logic [1:0]                       reset_cause_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [erel_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);
  import erel_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  erel_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  erel_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TIME_WIDTH    (TIME_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .mode_i            (mode_i),
    .subsys_i          (subsys_i),
    .raw_level_i       (raw_level_i),
    .escalated_level_i (escalated_level_i),
    .now_ticks_i       (now_ticks_i),
    .error_safe_i      (error_safe_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .action_o          (action_o),
    .reset_cause_o     (reset_cause_o)
  );

endmodule

// File: rtl/erel_ctrl.sv
module erel_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  erel_pkg::dp_status_t status_i,
  output erel_pkg::dp_cmd_t    cmd_o
);
  import erel_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = status_i.need_scan ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // The result waits here until the output register is free.
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/erel_dp.sv
module erel_dp #(
  parameter int unsigned HISTORY_DEPTH = 4,
  parameter int unsigned TIME_WIDTH    = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  erel_pkg::dp_cmd_t                   cmd_i,
  output erel_pkg::dp_status_t                status_o,
  input  logic [1:0]                          mode_i,
  input  logic [3:0]                          subsys_i,
  input  logic [2:0]                          raw_level_i,
  input  logic [2:0]                          escalated_level_i,
  input  logic [31:0]                         now_ticks_i,
  input  logic                                error_safe_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [erel_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [31:0]                         cfg_data_i,
  output logic [2:0]                          action_o,
  output logic [1:0]                          reset_cause_o
);
  import erel_pkg::*;

  localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

  // t lies within [start, start + len] in wrapping time.
  function automatic logic in_window(input logic [TIME_WIDTH-1:0] t,
                                     input logic [TIME_WIDTH-1:0] start,
                                     input logic [TIME_WIDTH-1:0] len);
    logic [TIME_WIDTH-1:0] win_end;
    logic [TIME_WIDTH-1:0] d_start;
    logic [TIME_WIDTH-1:0] d_end;
    win_end = start + len;
    d_start = t - start;
    d_end   = win_end - t;
    return !d_start[TIME_WIDTH-1] && !d_end[TIME_WIDTH-1];
  endfunction

  logic [31:0]           min_q;
  logic [31:0]           mon_q;
  logic [63:0]           min_ext, mon_ext, now_ext;
  logic [TIME_WIDTH-1:0] min_t, mon_t, now_t;

  logic [1:0]            mode_q;
  logic [3:0]            subsys_q;
  logic [2:0]            raw_q;
  logic [2:0]            esc_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic                  safe_q;

  logic [TIME_WIDTH-1:0] times_q [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]      ring_idx_q;
  logic [IDX_W-1:0]      scan_idx_q;
  logic [TIME_WIDTH-1:0] last_q;
  logic                  busy_q;
  logic [3:0]            busy_subsys_q;

  logic [2:0]            res_action_q, dec_action;
  logic [1:0]            res_cause_q, dec_cause;
  logic                  dec_need_scan;
  logic                  scan_escape;
  logic                  scan_last;
  logic [TIME_WIDTH-1:0] scan_time;
  logic                  last_none;

  assign cfg_ready_o = 1'b1;

  assign min_ext = {32'd0, min_q};
  assign mon_ext = {32'd0, mon_q};
  assign now_ext = {32'd0, now_ticks_i};
  assign min_t   = min_ext[TIME_WIDTH-1:0];
  assign mon_t   = mon_ext[TIME_WIDTH-1:0];
  assign now_t   = now_ext[TIME_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_INTERVAL_RESET;
      mon_q <= MONITOR_PERIOD_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_INTERVAL:   min_q <= cfg_data_i;
        CFG_MONITOR_PERIOD: mon_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input capture; a zero time stamp is taken as one so zero can mark empty.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q   <= mode_i;
      subsys_q <= subsys_i;
      raw_q    <= raw_level_i;
      esc_q    <= escalated_level_i;
      now_q    <= (now_t == '0) ? TIME_WIDTH'(1) : now_t;
      safe_q   <= error_safe_i;
    end
  end

  assign last_none = (last_q == '0);

  always_comb begin
    dec_action    = ACT_HOUSEKEEP;
    dec_cause     = CAUSE_NONE;
    dec_need_scan = 1'b0;
    if (mode_q == MODE_ERROR) begin
      if (raw_q == LEVEL_LOG_ONLY) begin
        dec_action = ACT_LOG_ONLY;
      end else if (safe_q) begin
        dec_action = ACT_IGN_RESET;
      end else if (busy_q && busy_subsys_q == subsys_q) begin
        dec_action = ACT_IGN_BUSY;
      end else if (esc_q < LEVEL_RECOVER) begin
        dec_action = ACT_NOTIFY;
      end else if (esc_q == LEVEL_FULL || busy_q) begin
        dec_action = ACT_FULL_RESET;
        dec_cause  = CAUSE_LEVEL;
      end else if (!last_none && min_t != '0 && in_window(now_q, last_q, min_t)) begin
        dec_action = ACT_FULL_RESET;
        dec_cause  = CAUSE_TOO_SOON;
      end else begin
        dec_action    = ACT_SVC_RECOVERY;
        dec_need_scan = !last_none && (mon_t != '0);
      end
    end
  end

  // One history entry is checked per cycle; an empty entry or one outside
  // the monitor period lets the recovery through.
  assign scan_time   = times_q[scan_idx_q];
  assign scan_escape = !valid_q[scan_idx_q] || !in_window(now_q, scan_time, mon_t);
  assign scan_last   = (scan_idx_q == LAST_IDX);

  assign status_o.need_scan = dec_need_scan;
  assign status_o.scan_done = scan_escape || scan_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      res_action_q <= dec_action;
      res_cause_q  <= dec_cause;
    end else if (cmd_i.scan && !scan_escape && scan_last) begin
      res_action_q <= ACT_FULL_RESET;
      res_cause_q  <= CAUSE_TOO_MANY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
    end else if (cmd_i.decide) begin
      scan_idx_q <= '0;
    end else if (cmd_i.scan && !scan_last) begin
      scan_idx_q <= scan_idx_q + IDX_W'(1);
    end
  end

  // The first recovery after a restart empties the ring before writing it.
  always_comb begin
    valid_d = last_none ? '0 : valid_q;
    valid_d[ring_idx_q] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      ring_idx_q    <= '0;
      last_q        <= '0;
      busy_q        <= 1'b0;
      busy_subsys_q <= '0;
    end else if (cmd_i.commit) begin
      if (mode_q == MODE_REC_DONE) begin
        busy_q <= 1'b0;
      end else if (mode_q == MODE_RESTART) begin
        busy_q <= 1'b0;
        last_q <= '0;
      end else if (res_action_q == ACT_SVC_RECOVERY) begin
        valid_q       <= valid_d;
        ring_idx_q    <= (ring_idx_q == LAST_IDX) ? '0 : ring_idx_q + IDX_W'(1);
        last_q        <= now_q;
        busy_q        <= 1'b1;
        busy_subsys_q <= subsys_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && mode_q == MODE_ERROR && res_action_q == ACT_SVC_RECOVERY) begin
      times_q[ring_idx_q] <= now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      action_o      <= res_action_q;
      reset_cause_o <= res_cause_q;
    end
  end

endmodule
